>>> sv/tns_pkg.sv
// Shared types and constants for the nearest-sample texture unit with repeat wrapping.
// No dependencies; every other file refers to this package by scoped names.
package tns_pkg;

    localparam int MAX_DIM_DEF   = 256;
    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W     = 32;
    localparam int ADDR_W      = 16;
    localparam int TEXEL_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 1;
    localparam int STORE_DEPTH = 1 << ADDR_W;
    localparam int DIM_RESET   = 256;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'b1;

    typedef enum logic
    {
        FUNC_WRITE  = 1'b0,
        FUNC_SAMPLE = 1'b1
    } func_t;

    // Load enables for the two coordinate stages
    typedef struct packed
    {
        logic ld1;
        logic ld2;
    } tns_stage_en_t;

endpackage

>>> sv/tns_ifs.sv
// Valid/ready channel interfaces for the texture unit: request and sampled-texel response.
// Depends on tns_pkg for field widths.
interface tns_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic signed [tns_pkg::COORD_W-1:0]   coord_u;
    logic signed [tns_pkg::COORD_W-1:0]   coord_v;
    logic        [tns_pkg::ADDR_W-1:0]    texel_address;
    logic        [tns_pkg::TEXEL_W-1:0]   texel_rgba;

    modport source (output valid, func, coord_u, coord_v, texel_address, texel_rgba,
                    input ready);
    modport sink   (input valid, func, coord_u, coord_v, texel_address, texel_rgba,
                    output ready);
endinterface

interface tns_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [tns_pkg::CHAN_W-1:0]    red;
    logic [tns_pkg::CHAN_W-1:0]    green;
    logic [tns_pkg::CHAN_W-1:0]    blue;
    logic [tns_pkg::CHAN_W-1:0]    alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

>>> sv/tns_coord.sv
// Two-stage coordinate unit: scales a wrapped fraction by dim-1, rounds half up, clamps.
// Depends on tns_pkg for the stage enable struct.
module tns_coord #(
    parameter int FRAC_BITS = tns_pkg::FRAC_BITS_DEF,
    parameter int MAX_DIM   = tns_pkg::MAX_DIM_DEF,
    localparam int IDX_W    = $clog2(MAX_DIM)
) (
    input  logic                     clk,
    input  tns_pkg::tns_stage_en_t   en,
    input  logic [FRAC_BITS-1:0]     frac,
    input  logic [IDX_W-1:0]         dim_m1,
    output logic [IDX_W-1:0]         idx
);

    localparam int PW = FRAC_BITS + IDX_W;
    localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

    logic [PW-1:0]    prod_reg;
    logic [PW:0]      sum;
    logic [IDX_W:0]   rounded;
    logic [IDX_W-1:0] idx_next;
    logic [IDX_W-1:0] idx_reg;

    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            prod_reg <= PW'(frac) * PW'(dim_m1);
        end
    end

    always_comb
    begin
        sum     = (PW + 1)'(prod_reg) + HALF;
        rounded = sum[PW:FRAC_BITS];
        if (rounded > {1'b0, dim_m1})
        begin
            idx_next = dim_m1;
        end
        else
        begin
            idx_next = rounded[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            idx_reg <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

>>> sv/texture_nearest_sample_wrap_top.sv
// Nearest-sample texture unit, repeat wrapping, over a 65536 x 32-bit texel store.
// Four stages: scale, round/clamp, address, store read. Throughput: one item per cycle
// unless a result waiting on the response port stalls the pipeline, set by the single store
// port shared by writes and reads after the address stage.
// Reset clears valid bits and sets both dimensions to 256; the store is not cleared.
module texture_nearest_sample_wrap_top #(
    parameter int MAX_DIM   = tns_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = tns_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tns_req_if.sink                          req,
    tns_rsp_if.source                        resp,
    input  logic                             cfg_we,
    input  logic [tns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tns_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CALC_W = (IDX_W + DIM_W + 1 > tns_pkg::ADDR_W) ?
                            IDX_W + DIM_W + 1 : tns_pkg::ADDR_W;
    localparam int DIM_RST = (tns_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : tns_pkg::DIM_RESET;

    // Configuration: dimensions stored already clamped to 1..MAX_DIM
    logic [DIM_W-1:0] cfg_dim;
    logic [DIM_W-1:0] w_reg;
    logic [IDX_W-1:0] w_m1_reg;
    logic [IDX_W-1:0] h_m1_reg;

    always_comb
    begin
        priority if (cfg_data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if (32'(cfg_data) > MAX_DIM)
        begin
            cfg_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            cfg_dim = DIM_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= DIM_W'(DIM_RST);
            w_m1_reg <= IDX_W'(DIM_RST - 1);
            h_m1_reg <= IDX_W'(DIM_RST - 1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tns_pkg::CFG_TEX_WIDTH:
                begin
                    w_reg    <= cfg_dim;
                    w_m1_reg <= IDX_W'(cfg_dim - DIM_W'(1));
                end
                tns_pkg::CFG_TEX_HEIGHT:
                begin
                    h_m1_reg <= IDX_W'(cfg_dim - DIM_W'(1));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pipeline handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic ready1, ready2, ready3, adv4, go3;

    logic                           func1_reg, func2_reg, func3_reg;
    logic [tns_pkg::ADDR_W-1:0]     waddr1_reg, waddr2_reg;
    logic [tns_pkg::TEXEL_W-1:0]    wdata1_reg, wdata2_reg, wdata3_reg;
    logic [tns_pkg::ADDR_W-1:0]     addr3_reg;
    logic [tns_pkg::ADDR_W-1:0]     addr3_next;
    logic [CALC_W-1:0]              addr_calc;
    logic [tns_pkg::TEXEL_W-1:0]    rd_data_reg;

    tns_pkg::tns_stage_en_t en;
    logic [IDX_W-1:0] x2;
    logic [IDX_W-1:0] y2;

    assign adv4   = !v4_reg || resp.ready;
    assign go3    = v3_reg && (func3_reg == tns_pkg::FUNC_WRITE || adv4);
    assign ready3 = !v3_reg || go3;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    assign req.ready = ready1;
    assign en.ld1    = ready1 && req.valid;
    assign en.ld2    = ready2 && v1_reg;

    always_comb
    begin
        v1_next = ready1 ? req.valid : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? v2_reg : v3_reg;
        priority if (go3 && func3_reg == tns_pkg::FUNC_SAMPLE)
        begin
            v4_next = 1'b1;
        end
        else if (resp.ready)
        begin
            v4_next = 1'b0;
        end
        else
        begin
            v4_next = v4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage 1: capture the write payload; the coordinate units scale the fractions
    always_ff @(posedge clk)
    begin
        if (en.ld1)
        begin
            func1_reg  <= req.func;
            waddr1_reg <= req.texel_address;
            wdata1_reg <= req.texel_rgba;
        end
    end

    tns_coord #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_coord_u (
        .clk    (clk),
        .en     (en),
        .frac   (req.coord_u[FRAC_BITS-1:0]),
        .dim_m1 (w_m1_reg),
        .idx    (x2)
    );

    tns_coord #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_coord_v (
        .clk    (clk),
        .en     (en),
        .frac   (req.coord_v[FRAC_BITS-1:0]),
        .dim_m1 (h_m1_reg),
        .idx    (y2)
    );

    // Stage 2: rounded and clamped column and row come out of the coordinate units
    always_ff @(posedge clk)
    begin
        if (en.ld2)
        begin
            func2_reg  <= func1_reg;
            waddr2_reg <= waddr1_reg;
            wdata2_reg <= wdata1_reg;
        end
    end

    // Stage 3: linear address for a sample, wrapped to the store's index width; a write keeps its own address
    always_comb
    begin
        addr_calc = CALC_W'(y2) * CALC_W'(w_reg) + CALC_W'(x2);
        if (func2_reg == tns_pkg::FUNC_WRITE)
        begin
            addr3_next = waddr2_reg;
        end
        else
        begin
            addr3_next = addr_calc[tns_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            func3_reg  <= func2_reg;
            addr3_reg  <= addr3_next;
            wdata3_reg <= wdata2_reg;
        end
    end

    // Stage 4: texel store, one port; a write leaves here with no result
    logic [tns_pkg::TEXEL_W-1:0] texel_mem [tns_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (go3)
        begin
            if (func3_reg == tns_pkg::FUNC_WRITE)
            begin
                texel_mem[addr3_reg] <= wdata3_reg;
            end
            else
            begin
                rd_data_reg <= texel_mem[addr3_reg];
            end
        end
    end

    assign resp.valid = v4_reg;
    assign resp.red   = rd_data_reg[7:0];
    assign resp.green = rd_data_reg[15:8];
    assign resp.blue  = rd_data_reg[23:16];
    assign resp.alpha = rd_data_reg[31:24];

    // A new result appears only after a sample left the address stage
    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v4_reg) |-> $past(go3 && func3_reg == tns_pkg::FUNC_SAMPLE))
        else $error("result raised without a sample leaving the address stage");

    // A stalled stage-one transaction is kept
    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |=> v1_reg)
        else $error("stage one dropped a stalled transaction");

    // Column and row stay inside the texture
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && func2_reg == tns_pkg::FUNC_SAMPLE) |-> (x2 <= w_m1_reg && y2 <= h_m1_reg))
        else $error("sample index outside the texture");

    // A write never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (go3 && func3_reg == tns_pkg::FUNC_WRITE && !v4_reg) |=> !v4_reg)
        else $error("write produced a result");

    // A result waiting under backpressure keeps its data
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !resp.ready) |=> (v4_reg && $stable(rd_data_reg)))
        else $error("stalled result changed");

endmodule

>>> tb/texture_sample_checker.sv
// Checker for the nearest-sample texture unit: watches the request, response and config ports.
// Keeps its own texel store and dimensions, predicts each sampled texel, compares in order.
// Depends on tns_pkg and the channel interfaces in tns_ifs.sv.
module texture_sample_checker #(
    parameter int MAX_DIM   = tns_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = tns_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tns_req_if                               req,
    tns_rsp_if                               resp,
    input  logic                             cfg_we,
    input  logic [tns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tns_pkg::CFG_W-1:0]        cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               texels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Packed so that the layout matches a stored RGBA8 word
    typedef struct packed
    {
        logic [tns_pkg::CHAN_W-1:0] alpha;
        logic [tns_pkg::CHAN_W-1:0] blue;
        logic [tns_pkg::CHAN_W-1:0] green;
        logic [tns_pkg::CHAN_W-1:0] red;
    } texel_t;

    logic [tns_pkg::TEXEL_W-1:0] texel_mem [0:tns_pkg::STORE_DEPTH-1];
    logic [tns_pkg::CFG_W-1:0]   width_reg;
    logic [tns_pkg::CFG_W-1:0]   height_reg;
    texel_t                      expected_texels [$];

    function automatic int unsigned usable_dim(logic [tns_pkg::CFG_W-1:0] d);
        if (d == '0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    // Repeat wrap: keep the fraction, scale by dim-1, round half up, clamp to the last texel
    function automatic int unsigned wrapped_index(logic [31:0] coord, int unsigned dim);
        longint unsigned frac;
        longint unsigned idx;
        frac = coord & ((64'd1 << FRAC_BITS) - 1);
        idx  = (frac * (dim - 1) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (idx > dim - 1)
            idx = dim - 1;
        return int'(idx);
    endfunction

    function automatic texel_t fetch_nearest(logic [31:0] u, logic [31:0] v);
        int unsigned               w;
        int unsigned               h;
        logic [tns_pkg::ADDR_W-1:0] addr;
        w    = usable_dim(width_reg);
        h    = usable_dim(height_reg);
        addr = tns_pkg::ADDR_W'(wrapped_index(v, h) * w + wrapped_index(u, w));
        return texel_t'(texel_mem[addr]);
    endfunction

    task automatic compare_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        texel_t want;
        if (!rst_n)
        begin
            width_reg  = tns_pkg::CFG_W'(tns_pkg::DIM_RESET);
            height_reg = tns_pkg::CFG_W'(tns_pkg::DIM_RESET);
            expected_texels.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tns_pkg::CFG_TEX_WIDTH:  width_reg  = cfg_data;
                    tns_pkg::CFG_TEX_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.func == tns_pkg::FUNC_WRITE)
                    texel_mem[req.texel_address] = req.texel_rgba;
                else
                    expected_texels.push_back(fetch_nearest(req.coord_u, req.coord_v));
            end
            if (resp.valid && resp.ready)
            begin
                if (expected_texels.size() == 0)
                begin
                    $error("unexpected sampled texel: red %0h green %0h blue %0h alpha %0h",
                           resp.red, resp.green, resp.blue, resp.alpha);
                    fail_count++;
                end
                else
                begin
                    want = expected_texels.pop_front();
                    compare_channel("red", want.red, resp.red);
                    compare_channel("green", want.green, resp.green);
                    compare_channel("blue", want.blue, resp.blue);
                    compare_channel("alpha", want.alpha, resp.alpha);
                    texels_checked++;
                end
            end
            pending = expected_texels.size();
        end
    end

endmodule

>>> tb/tb_texture_nearest_sample_wrap_top.sv
// Testbench top for texture_nearest_sample_wrap_top: clock, reset, stimulus and verdict.
// Depends on tns_pkg, tns_ifs.sv, the block itself and texture_sample_checker.
module tb_texture_nearest_sample_wrap_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM     = tns_pkg::MAX_DIM_DEF;
    localparam int FRAC_BITS   = tns_pkg::FRAC_BITS_DEF;
    localparam int ITEM_TARGET = 1550;
    localparam int FIXED_SIZES = 11;
    localparam int RANDOM_SIZES = 3;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [tns_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tns_pkg::CFG_W-1:0]     cfg_data;
    int                            fail_count;
    int                            pending;
    int                            texels_checked;

    bit                            written [0:tns_pkg::STORE_DEPTH-1];
    logic [tns_pkg::CFG_W-1:0]     width_sel;
    logic [tns_pkg::CFG_W-1:0]     height_sel;
    int                            items_sent;
    int                            sizes_run;
    int                            gap_pct;
    int                            stall_pct;

    tns_req_if req_if();
    tns_rsp_if rsp_if();

    texture_nearest_sample_wrap_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .resp      (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    texture_sample_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_if),
        .resp           (rsp_if),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .texels_checked (texels_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("texture_nearest_sample_wrap_top regression: fail");
        $finish;
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int unsigned dim_in_use(logic [tns_pkg::CFG_W-1:0] d);
        if (d == '0)
            return 1;
        return (d > MAX_DIM) ? MAX_DIM : d;
    endfunction

    // Used only to steer samples onto texels that already hold data
    function automatic int unsigned axis_position(logic [31:0] coord, int unsigned dim);
        longint unsigned scaled;
        scaled = ((coord & ((64'd1 << FRAC_BITS) - 1)) * (dim - 1)
                  + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (scaled > dim - 1) ? dim - 1 : int'(scaled);
    endfunction

    function automatic logic [tns_pkg::ADDR_W-1:0] landing_address(logic [31:0] u,
                                                                   logic [31:0] v);
        int unsigned w;
        int unsigned h;
        w = dim_in_use(width_sel);
        h = dim_in_use(height_sel);
        return tns_pkg::ADDR_W'(axis_position(v, h) * w + axis_position(u, w));
    endfunction

    // Random coordinate, often with the fraction forced onto a wrap or rounding boundary
    function automatic logic [31:0] pick_coord(int unsigned dim);
        logic [31:0]     c;
        logic [31:0]     mask;
        longint unsigned k;
        longint unsigned f;
        c    = $urandom();
        mask = (32'd1 << FRAC_BITS) - 1;
        case ($urandom_range(7))
            0: c = c & ~mask;
            1: c = c | mask;
            2: c = (c & ~mask) | (32'd1 << (FRAC_BITS - 1));
            3:
            begin
                if (dim > 1)
                begin
                    k = $urandom_range(dim - 1, 1);
                    f = ((k << FRAC_BITS) - (64'd1 << (FRAC_BITS - 1)) + dim - 2) / (dim - 1);
                    f = f - $urandom_range(1);
                    c = (c & ~mask) | (32'(f) & mask);
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic drive_request(tns_pkg::func_t f, logic [31:0] u, logic [31:0] v,
                                 logic [tns_pkg::ADDR_W-1:0] addr, logic [31:0] rgba);
        // rotate the idling pattern so gaps land on every pipeline phase
        if (items_sent % 64 == 0)
        begin
            case (idle_mode_t'((items_sent / 64) % 4))
                IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin gap_pct = 87; stall_pct = 0;  end
                IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 87; end
                default:       begin gap_pct = 10; stall_pct = 10; end
            endcase
        end
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        req_if.valid         <= 1'b1;
        req_if.func          <= f;
        req_if.coord_u       <= u;
        req_if.coord_v       <= v;
        req_if.texel_address <= addr;
        req_if.texel_rgba    <= rgba;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
        if (f == tns_pkg::FUNC_WRITE)
            written[addr] = 1'b1;
        items_sent++;
    endtask

    task automatic write_texel(logic [tns_pkg::ADDR_W-1:0] addr, logic [31:0] rgba);
        drive_request(tns_pkg::FUNC_WRITE, $urandom(), $urandom(), addr, rgba);
    endtask

    // Fill the target texel first when it was never written
    task automatic sample_at(logic [31:0] u, logic [31:0] v);
        logic [tns_pkg::ADDR_W-1:0] target;
        target = landing_address(u, v);
        if (!written[target])
            write_texel(target, $urandom());
        drive_request(tns_pkg::FUNC_SAMPLE, u, v, tns_pkg::ADDR_W'($urandom()), $urandom());
    endtask

    // Hold the sender until the pipeline has drained, writes included
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_dims(logic [tns_pkg::CFG_W-1:0] w, logic [tns_pkg::CFG_W-1:0] h);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= tns_pkg::CFG_TEX_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= tns_pkg::CFG_TEX_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_we     <= 1'b0;
        width_sel  = w;
        height_sel = h;
        sizes_run++;
    endtask

    task automatic random_traffic(int budget);
        int          stop;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        stop = items_sent + budget;
        w    = dim_in_use(width_sel);
        h    = dim_in_use(height_sel);
        while (items_sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                sample_at(pick_coord(w), pick_coord(h));
            else if (pick < 85)
                write_texel(tns_pkg::ADDR_W'($urandom_range(w * h - 1)), $urandom());
            else
                write_texel(tns_pkg::ADDR_W'($urandom()), $urandom());
        end
    endtask

    initial
    begin : stimulus
        logic [tns_pkg::CFG_W-1:0] plan_w [0:FIXED_SIZES-1];
        logic [tns_pkg::CFG_W-1:0] plan_h [0:FIXED_SIZES-1];
        int                        budget;
        plan_w = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd7, 9'd16, 9'd100, 9'd256, 9'd1, 9'd3};
        plan_h = '{9'd1, 9'd256, 9'd0, 9'd300, 9'd3, 9'd5, 9'd16, 9'd37, 9'd1, 9'd256, 9'd256};
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = tns_pkg::CFG_TEX_WIDTH;
        cfg_data             = '0;
        req_if.valid         = 1'b0;
        req_if.func          = tns_pkg::FUNC_WRITE;
        req_if.coord_u       = '0;
        req_if.coord_v       = '0;
        req_if.texel_address = '0;
        req_if.texel_rgba    = '0;
        width_sel            = tns_pkg::CFG_W'(tns_pkg::DIM_RESET);
        height_sel           = tns_pkg::CFG_W'(tns_pkg::DIM_RESET);
        gap_pct              = 0;
        stall_pct            = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme texels and addresses, wrap edges, half-texel rounding, overwrite
        write_texel(16'h0000, 32'hFFFF_FFFF);
        write_texel(16'hFFFF, 32'h0000_0000);
        write_texel(16'h8000, 32'hA5C3_5A3C);
        sample_at(32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_FFFF, 32'h0000_FFFF);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF);
        sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        sample_at(32'h0000_8000, 32'h0000_8000);
        sample_at(32'h7FFF_8000, 32'h8000_7FFF);
        sample_at(32'h0001_0000, 32'hFFFF_0000);
        sample_at(32'h0000_0081, 32'h0000_0080);
        write_texel(16'h0000, 32'h1234_5678);
        sample_at(32'h0000_0000, 32'h0000_0000);

        budget = (ITEM_TARGET - items_sent) / (FIXED_SIZES + RANDOM_SIZES);
        for (int i = 0; i < FIXED_SIZES; i++)
        begin
            set_dims(plan_w[i], plan_h[i]);
            random_traffic(budget);
        end
        for (int i = 0; i < RANDOM_SIZES; i++)
        begin
            set_dims(tns_pkg::CFG_W'($urandom_range(256, 1)),
                     tns_pkg::CFG_W'($urandom_range(256, 1)));
            random_traffic(budget);
        end

        req_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("Sent %0d transactions over %0d texture sizes; %0d sampled texels compared.",
                 items_sent, sizes_run, texels_checked);
        if (fail_count == 0 && pending == 0)
            $display("texture_nearest_sample_wrap_top regression: pass");
        else
            $display("texture_nearest_sample_wrap_top regression: fail");
        $finish;
    end

endmodule

>>> texture_nearest_sample_wrap_top.f
sv/tns_pkg.sv
sv/tns_ifs.sv
sv/tns_coord.sv
sv/texture_nearest_sample_wrap_top.sv
tb/texture_sample_checker.sv
tb/tb_texture_nearest_sample_wrap_top.sv
